// File: design/canonical_kmer_background_match_top_assert.svh
// Assertion macros used by ckbm_table. Clock clk_i, reset rst_ni.
`ifndef CANONICAL_KMER_BACKGROUND_MATCH_TOP_ASSERT_SVH
`define CANONICAL_KMER_BACKGROUND_MATCH_TOP_ASSERT_SVH

// Property holds at every edge outside reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Cause at one edge implies effect at the next edge.
`define ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) \
    else $error(msg);

`endif

// File: design/ckbm_pkg.sv
package ckbm_pkg;

  localparam int KMER_LEN      = 31;
  localparam int KW            = 2 * KMER_LEN;
  localparam int OUT_W         = 62;
  localparam int FILL_W        = 5;
  localparam int BG_TABLE_SIZE = 1048576;
  localparam int ADDR_W        = $clog2(BG_TABLE_SIZE);

  localparam logic [ADDR_W-1:0] ADDR_MAX   = ADDR_W'(BG_TABLE_SIZE - 1);
  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(KMER_LEN);
  localparam logic [7:0]        CH_LOWER_A = 8'h61;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  localparam logic REG_BG_ENABLE = 1'b0;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_code_t;

  // Stage after the window: at most one table access per item.
  typedef struct packed {
    logic          rd;
    logic          wr;
    logic [KW-1:0] canon;
  } s1_t;

  // Stage after the table read.
  typedef struct packed {
    logic          valid;
    logic          match;
    logic [KW-1:0] canon;
  } s2_t;

  function automatic base_code_t base_code(input logic [7:0] ch);
    base_code_t r;
    r.ok   = 1'b1;
    r.code = CODE_A;
    case (ch)
      "A", "a": r.code = CODE_A;
      "C", "c": r.code = CODE_C;
      "G", "g": r.code = CODE_G;
      "T", "t": r.code = CODE_T;
      default:  r.ok   = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: design/ckbm_window.sv
module ckbm_window
  import ckbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       adv_i,
  input  logic       func_i,
  input  logic [7:0] base_i,
  input  logic       read_start_i,
  output s1_t        s1_o
);

  logic [KW-1:0]     fwd_q, fwd_d, rev_q, rev_d, fwd_0, rev_0, canon;
  logic [FILL_W-1:0] fill_q, fill_d, fill_0;
  base_code_t        bc;
  logic              full;
  s1_t               s1_q, s1_d;

  always_comb begin
    bc     = base_code(base_i);
    fwd_0  = read_start_i ? '0 : fwd_q;
    rev_0  = read_start_i ? '0 : rev_q;
    fill_0 = read_start_i ? '0 : fill_q;
    fwd_d  = fwd_q;
    rev_d  = rev_q;
    fill_d = fill_q;
    if (accept_i) begin
      if (bc.ok) begin
        fwd_d  = {fwd_0[KW-3:0], bc.code};
        rev_d  = {~bc.code, rev_0[KW-1:2]};
        fill_d = (fill_0 < FILL_FULL) ? fill_0 + FILL_W'(1) : fill_0;
      end else begin
        fwd_d  = '0;
        rev_d  = '0;
        fill_d = '0;
      end
    end
    full  = accept_i && bc.ok && (fill_d == FILL_FULL);
    canon = (fwd_d >= rev_d) ? fwd_d : rev_d;
    s1_d.canon = canon;
    s1_d.rd    = full && !func_i;
    s1_d.wr    = full && func_i && (base_i < CH_LOWER_A) && (canon[ADDR_W-1:0] != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= '0;
      rev_q  <= '0;
      fill_q <= '0;
      s1_q   <= '0;
    end else begin
      fwd_q  <= fwd_d;
      rev_q  <= rev_d;
      fill_q <= fill_d;
      if (adv_i) begin
        s1_q <= s1_d;
      end
    end
  end

  assign s1_o = s1_q;

endmodule

// File: design/ckbm_table.sv
module ckbm_table
  import ckbm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  s1_t  s1_i,
  output logic busy_o,
  output s2_t  s2_o
);

  `include "canonical_kmer_background_match_top_assert.svh"

  logic [KW-1:0]     mem [BG_TABLE_SIZE];
  logic [KW-1:0]     rdata_q;
  logic [KW-1:0]     s2_canon_q;
  logic              s2_valid_q;
  logic              clearing_q, clearing_d;
  logic [ADDR_W-1:0] clr_idx_q, clr_idx_d;
  logic              we, re;
  logic [ADDR_W-1:0] waddr;
  logic [KW-1:0]     wdata;

  always_comb begin
    clearing_d = clearing_q;
    clr_idx_d  = clr_idx_q;
    if (clearing_q) begin
      clr_idx_d = clr_idx_q + ADDR_W'(1);
      if (clr_idx_q == ADDR_MAX) begin
        clearing_d = 1'b0;
      end
    end
    we    = clearing_q || (adv_i && s1_i.wr);
    waddr = clearing_q ? clr_idx_q : s1_i.canon[ADDR_W-1:0];
    wdata = clearing_q ? '0 : s1_i.canon;
    re    = adv_i && s1_i.rd;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[s1_i.canon[ADDR_W-1:0]];
    end
    if (adv_i) begin
      s2_canon_q <= s1_i.canon;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_idx_q  <= clr_idx_d;
      if (adv_i) begin
        s2_valid_q <= s1_i.rd;
      end
    end
  end

  assign busy_o      = clearing_q;
  assign s2_o.valid  = s2_valid_q;
  assign s2_o.canon  = s2_canon_q;
  assign s2_o.match  = (rdata_q == s2_canon_q);

  `ASSERT_HOLDS(a_no_access_in_clear, clearing_q |-> !(s1_i.rd || s1_i.wr), "access while clearing")
  `ASSERT_NEXT(a_clear_ends, clearing_q && (clr_idx_q == ADDR_MAX), !clearing_q, "clear overrun")
  `ASSERT_NEXT(a_clear_once, !clearing_q, !clearing_q, "clear restarted")
  `ASSERT_NEXT(a_s2_hold, !adv_i && s2_valid_q, s2_valid_q && $stable(s2_canon_q), "s2 lost")

endmodule

// File: design/canonical_kmer_background_match_top.sv
// Channel   Dir  Handshake             Payload
// s_axis    in   tvalid/tready         tdata: base; tuser: func, read_start
// m_axis    out  tvalid/tready         tdata: canonical_kmer; tuser: background_hit
// apb       in   psel/penable/pready   reg 0 at 0x0: bg_enable
//
// One base per cycle while s_axis_tready is high; a result passes the window
// register, the table read and the output register before it leaves.
// The table is a one-port-write, one-port-read memory; a load writes in the
// same stage where a count reads, so accesses never overlap.
// After reset a clearing pass zeros all 1048576 table entries, with
// s_axis_tready low throughout. APB writes are taken throughout.
// A stalled m_axis freezes all stages; s_axis_tready drops with it.
module canonical_kmer_background_match_top
  import ckbm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] base
  input  logic [1:0]  s_axis_tuser,   // [0] func, [1] read_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [61:0] canonical_kmer, [63:62] zero
  output logic        m_axis_tuser,   // [0] background_hit
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             adv, accept, busy;
  s1_t              s1;
  s2_t              s2;
  logic             bg_enable_q;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_kmer_q;
  logic             out_hit_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv && !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ckbm_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .adv_i        (adv),
    .func_i       (s_axis_tuser[0]),
    .base_i       (s_axis_tdata),
    .read_start_i (s_axis_tuser[1]),
    .s1_o         (s1)
  );

  ckbm_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .s1_i   (s1),
    .busy_o (busy),
    .s2_o   (s2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_enable_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && (paddr[2] == REG_BG_ENABLE)) begin
        bg_enable_q <= pwdata[0];
      end
      if (adv) begin
        out_valid_q <= s2.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_kmer_q <= OUT_W'(s2.canon);
      out_hit_q  <= bg_enable_q && s2.match;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_kmer_q};
  assign m_axis_tuser  = out_hit_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_BG_ENABLE) ? {31'b0, bg_enable_q} : 32'b0;

endmodule

// File: test/canonical_kmer_background_match_top_test.sv
module canonical_kmer_background_match_top_test;
  import ckbm_pkg::*;

  localparam int WATCHDOG_LIMIT  = 5_000_000;
  localparam int ITEMS_PER_PHASE = 500;
  localparam int DRAIN_CYCLES    = 12;

  typedef logic [7:0] strand_t[$];

  typedef struct packed {
    logic [OUT_W-1:0] kmer;
    logic             hit;
  } kmer_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] base
  logic [1:0]  s_axis_tuser;   // [0] func, [1] read_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [61:0] canonical_kmer, [63:62] zero
  logic        m_axis_tuser;   // [0] background_hit
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [KW-1:0] fwd_win = '0;
  logic [KW-1:0] rev_win = '0;
  int unsigned   fill_bases = 0;
  logic          bg_enable_mdl = 1'b0;
  logic [KW-1:0] bg_slots [int unsigned];

  kmer_result_t kmer_expected[$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           idle_cycles = 0;
  bit           idle_on = 1'b1;

  canonical_kmer_background_match_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic int nucleotide_code(input logic [7:0] ch);
    case (ch | 8'h20)
      "a": return int'(CODE_A);
      "c": return int'(CODE_C);
      "g": return int'(CODE_G);
      "t": return int'(CODE_T);
      default: return -1;
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected %h, got %h", what, want, got);
  endfunction

  // Roll one base into the window; queue the k-mer it yields in count mode, or store it in load mode.
  function automatic void predict_base(input logic load, input logic [7:0] ch,
                                       input logic rs);
    int            code;
    logic [KW-1:0] canon;
    int unsigned   slot;
    logic          hit;
    kmer_result_t  res;
    code = nucleotide_code(ch);
    if (rs || code < 0) begin
      fwd_win    = '0;
      rev_win    = '0;
      fill_bases = 0;
    end
    if (code < 0)
      return;
    fwd_win = {fwd_win[KW-3:0], 2'(code)};
    rev_win = {~2'(code), rev_win[KW-1:2]};
    if (fill_bases < KMER_LEN)
      fill_bases++;
    if (fill_bases < KMER_LEN)
      return;
    canon = (fwd_win >= rev_win) ? fwd_win : rev_win;
    slot  = int'(64'(canon) % 64'(BG_TABLE_SIZE));
    if (load) begin
      if (ch < CH_LOWER_A && slot != 0)
        bg_slots[slot] = canon;
    end else begin
      hit = bg_enable_mdl && bg_slots.exists(slot) && bg_slots[slot] == canon;
      res.kmer = canon;
      res.hit  = hit;
      kmer_expected = {kmer_expected, res};
    end
  endfunction

  function automatic strand_t run_then(input logic [7:0] lead, input int lead_n,
                                       input string tail);
    strand_t s;
    repeat (lead_n) s = {s, lead};
    for (int i = 0; i < tail.len(); i++)
      s = {s, 8'(tail[i])};
    return s;
  endfunction

  function automatic strand_t revcomp(input strand_t s);
    strand_t    r;
    logic [7:0] c;
    for (int i = s.size() - 1; i >= 0; i--) begin
      case (s[i])
        "A": c = "T";
        "C": c = "G";
        "G": c = "C";
        default: c = "A";
      endcase
      r = {r, c};
    end
    return r;
  endfunction

  function automatic strand_t lower_case(input strand_t s, input bit every);
    foreach (s[i])
      if (every || $urandom_range(0, 1))
        s[i] = s[i] | 8'h20;
    return s;
  endfunction

  function automatic logic [7:0] pick_base();
    case ($urandom_range(0, 3))
      0: return "A";
      1: return "C";
      2: return "G";
      default: return "T";
    endcase
  endfunction

  task automatic send_base(input logic load, input logic [7:0] ch, input logic rs);
    int gap;
    bit taken;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= {rs, load};
    do begin
      @(negedge clk_i);
      taken = (s_axis_tready === 1'b1);
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
    predict_base(load, ch, rs);
  endtask

  task automatic send_strand(input logic load, input strand_t s);
    foreach (s[i])
      send_base(load, s[i], i == 0);
  endtask

  // Hold off until every k-mer is out and loads have left the pipeline.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (kmer_expected.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bg_enable(input logic en);
    logic [31:0] readback;
    bit          ready_seen;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_BG_ENABLE);
    pwdata  <= {31'b0, en};
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ready_seen = (pready === 1'b1);
      @(posedge clk_i);
    end while (!ready_seen);
    bg_enable_mdl = en;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ready_seen = (pready === 1'b1);
      readback   = prdata;
      @(posedge clk_i);
    end while (!ready_seen);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== {31'b0, en})
      flag_mismatch("bg_enable readback", {32'b0, 31'b0, en}, {32'b0, readback});
  endtask

  task automatic test_window_extremes();
    strand_t s;
    write_bg_enable(1'b0);
    send_base(1'b0, 8'h00, 1'b1);
    send_base(1'b0, 8'hFF, 1'b0);
    send_strand(1'b0, run_then("A", KMER_LEN, ""));
    send_base(1'b0, "t", 1'b0);
    send_base(1'b0, "g", 1'b0);
    send_base(1'b1, "c", 1'b0);
    send_base(1'b0, "C", 1'b0);
    send_base(1'b0, "N", 1'b0);
    s = run_then("T", KMER_LEN - 1, "");
    send_strand(1'b0, s);
    send_base(1'b0, "T", 1'b1);
    send_strand(1'b0, run_then("G", KMER_LEN, "ca"));
  endtask

  task automatic test_background_hits();
    strand_t hit_seq;
    strand_t clash_seq;
    strand_t zero_seq;
    strand_t soft_seq;
    hit_seq   = run_then("T", 21, "CAGTACGGAT");
    clash_seq = run_then("T", 20, "GCAGTACGGAT");
    zero_seq  = run_then("T", 21, "AAAAAAAAAA");
    soft_seq  = run_then("G", 25, "ACTTAC");
    wait_idle();
    write_bg_enable(1'b1);
    send_strand(1'b1, hit_seq);
    send_strand(1'b1, zero_seq);
    send_strand(1'b1, lower_case(soft_seq, 1'b1));
    send_strand(1'b0, clash_seq);
    send_strand(1'b0, hit_seq);
    send_strand(1'b0, zero_seq);
    send_strand(1'b0, soft_seq);
    send_strand(1'b0, lower_case(revcomp(hit_seq), 1'b1));
  endtask

  task automatic test_random_phases();
    logic [2:0]  plan;
    int          goal;
    int          mode;
    int          pos;
    logic [7:0]  junk;
    strand_t     strand;
    strand_t     replay;
    plan = 3'b101;
    for (int p = 0; p < 3; p++) begin
      wait_idle();
      write_bg_enable(plan[p]);
      goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < goal) begin
        idle_on = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 3) != 0) begin
          strand.delete();
          repeat ($urandom_range(KMER_LEN, KMER_LEN + 17)) strand = {strand, pick_base()};
          mode = $urandom_range(0, 9);
          if (mode < 6)
            send_strand(1'b1, strand);
          else if (mode < 8)
            send_strand(1'b1, lower_case(strand, 1'b0));
          replay = $urandom_range(0, 1) ? revcomp(strand) : strand;
          if ($urandom_range(0, 1))
            replay = lower_case(replay, 1'b0);
          if ($urandom_range(0, 6) == 0) begin
            do junk = 8'($urandom_range(0, 255)); while (nucleotide_code(junk) >= 0);
            pos = $urandom_range(0, replay.size() - 1);
            replay[pos] = junk;
          end
          send_strand(1'b0, replay);
        end else begin
          repeat ($urandom_range(4, 20))
            send_base(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      $urandom_range(0, 7) == 0);
        end
      end
    end
  endtask

  // Result sink with random back-pressure.
  initial begin
    int stall;
    bit got;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        got = (m_axis_tvalid === 1'b1);
        @(posedge clk_i);
      end while (!got);
    end
  end

  always @(negedge clk_i) begin : check_results
    kmer_result_t want;
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (kmer_expected.size() == 0) begin
        flag_mismatch("unexpected k-mer", '0, m_axis_tdata);
      end else begin
        want = kmer_expected.pop_front();
        if (m_axis_tdata !== {{(64 - OUT_W){1'b0}}, want.kmer})
          flag_mismatch("canonical_kmer", {{(64 - OUT_W){1'b0}}, want.kmer}, m_axis_tdata);
        if (m_axis_tuser !== want.hit)
          flag_mismatch("background_hit", {63'b0, want.hit}, {63'b0, m_axis_tuser});
      end
    end
  end

  always @(negedge clk_i) begin
    if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("canonical_kmer_background_match_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_window_extremes();
    test_background_hits();
    test_random_phases();
    wait_idle();
    if (mismatches == 0 && kmer_expected.size() == 0) begin
      $display("canonical_kmer_background_match_top: match");
    end else begin
      $display("canonical_kmer_background_match_top: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/ckbm_pkg.sv
design/ckbm_window.sv
design/ckbm_table.sv
design/canonical_kmer_background_match_top.sv
test/canonical_kmer_background_match_top_test.sv
